// ===== hdl/sct_pkg.sv =====
`timescale 1ns / 1ps
package sct_pkg;

  // Input item kinds
  localparam logic [1:0] IN_RX     = 2'd0;
  localparam logic [1:0] IN_SAMPLE = 2'd1;
  localparam logic [1:0] IN_TICK   = 2'd2;

  // Frame header characters
  localparam logic [7:0] CH_C = 8'd67;
  localparam logic [7:0] CH_O = 8'd79;
  localparam logic [7:0] CH_M = 8'd77;

  // Command bytes
  localparam logic [7:0] CMD_SET_SP      = 8'hA0;
  localparam logic [7:0] CMD_SP_UP       = 8'hA1;
  localparam logic [7:0] CMD_SP_DOWN     = 8'hA2;
  localparam logic [7:0] CMD_CTL_TOGGLE  = 8'hA3;
  localparam logic [7:0] CMD_DELAY_ON    = 8'hA4;
  localparam logic [7:0] CMD_DELAY_OFF   = 8'hA5;
  localparam logic [7:0] CMD_MANUAL      = 8'hA6;
  localparam logic [7:0] CMD_TEMP_REPORT = 8'hA8;
  localparam logic [7:0] CMD_ON_COUNT    = 8'hAA;
  localparam logic [7:0] CMD_OFF_COUNT   = 8'hAB;
  localparam logic [7:0] CMD_STATE       = 8'hAE;

  // Reply tags
  localparam logic [7:0] TAG_TEMP      = 8'hA8;
  localparam logic [7:0] TAG_ON_COUNT  = 8'hAA;
  localparam logic [7:0] TAG_OFF_COUNT = 8'hAB;
  localparam logic [7:0] TAG_STATE     = 8'hAE;

  // Drive levels
  localparam logic [7:0] DRIVE_OFF  = 8'h00;
  localparam logic [7:0] DRIVE_MID  = 8'h80;
  localparam logic [7:0] DRIVE_FULL = 8'hFF;
  localparam logic [7:0] FLAGS_BASE = 8'h80;
  localparam logic [7:0] STATE_PAD  = 8'hFF;

  // Reply frame length in bytes
  localparam int unsigned FRAME_LEN = 6;

  // Default depth of the job queue
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_O    = 4'b0010,
    PH_M    = 4'b0100,
    PH_DATA = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_STATE = 2'd0,
    KIND_TEMP  = 2'd1,
    KIND_COUNT = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tag;
    logic [15:0] data;
  } frame_t;

  typedef struct packed {
    logic [1:0] nframes;
    frame_t     f0;
    frame_t     f1;
    logic [7:0] dac;
    logic       ctl;
  } job_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

  function automatic frame_t state_frame(logic ctl, logic doff, logic don);
    frame_t f;
    f.kind = KIND_STATE;
    f.tag  = TAG_STATE;
    f.data = {8'd0, FLAGS_BASE | {5'd0, don, doff, ctl}};
    return f;
  endfunction

endpackage

// ===== hdl/sct_front.sv =====
`timescale 1ns / 1ps
module sct_front import sct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [1:0] command_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] adc_sample_i,
  output job_t       job_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  left_q, left_d;
  logic [7:0]  p0_q, p0_d, p1_q, p1_d;
  logic [15:0] sp_q, sp_d;
  logic [13:0] temp_q, temp_d;
  logic        ctl_q, ctl_d, man_q, man_d, rep_q, rep_d;
  logic        don_q, don_d, doff_q, doff_d;
  logic [7:0]  ml_q, ml_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  drive_q, drive_d;

  logic        counting, exec, on_kind;
  logic [1:0]  left_v;
  logic [13:0] frac_r, frac_q;
  logic [23:0] meas, target;
  logic [1:0]  nf;
  frame_t      f0, f1;

  // Decode the item and work out the next state and the reply job
  always_comb begin
    phase_d = phase_q;  left_d = left_q;  p0_d = p0_q;  p1_d = p1_q;
    sp_d = sp_q;  temp_d = temp_q;  ctl_d = ctl_q;  man_d = man_q;
    rep_d = rep_q;  don_d = don_q;  doff_d = doff_q;  ml_d = ml_q;
    cnt_d = cnt_q;  drive_d = drive_q;
    exec = 1'b0;  on_kind = 1'b0;  left_v = left_q;
    nf = 2'd0;  f0 = '0;  f1 = '0;
    counting = don_q | doff_q;
    frac_r = 14'(16'(adc_sample_i) * 16'd55);
    frac_q = 14'((frac_r + (frac_r >> 8) + 14'd1) >> 8);
    meas   = 24'(adc_sample_i) * 24'd10000;
    target = 24'(sp_q) * 24'd255;

    case (command_i)
      IN_RX: begin
        if (!counting) begin
          case (phase_q)
            PH_HUNT: if (rx_byte_i == CH_C) phase_d = PH_O;
            PH_O:    phase_d = (rx_byte_i == CH_O) ? PH_M : PH_HUNT;
            PH_M: begin
              if (rx_byte_i == CH_M) begin
                phase_d = PH_DATA;
                left_d  = 2'd3;
              end else begin
                phase_d = PH_HUNT;
              end
            end
            PH_DATA: begin
              left_v = (left_q == 2'd0) ? 2'd1 : left_q;
              if (left_v == 2'd3) p0_d = rx_byte_i;
              else if (left_v == 2'd2) p1_d = rx_byte_i;
              left_d = left_v - 2'd1;
              if (left_v == 2'd1) begin
                phase_d = PH_HUNT;
                exec    = 1'b1;
              end
            end
            default: phase_d = PH_HUNT;
          endcase
        end
      end
      IN_SAMPLE: begin
        temp_d = 14'(16'(adc_sample_i) * 16'd39) + frac_q;
        if (rep_q) begin
          nf = 2'd1;
          f0 = '{KIND_TEMP, TAG_TEMP, {2'd0, temp_d}};
        end
        if (ctl_q) begin
          if (meas > target) drive_d = DRIVE_OFF;
          else if (meas < target) drive_d = DRIVE_FULL;
          else drive_d = DRIVE_MID;
        end else if (!counting) begin
          drive_d = man_q ? ml_q : DRIVE_MID;
        end
      end
      IN_TICK: begin
        if (counting) begin
          cnt_d = (cnt_q != 16'd0) ? cnt_q - 16'd1 : cnt_q;
          nf = 2'd1;
          if (cnt_d == 16'd0) begin
            ctl_d  = !ctl_q;
            don_d  = 1'b0;
            doff_d = 1'b0;
            if (doff_q) drive_d = DRIVE_MID;
            f0 = state_frame(ctl_d, 1'b0, 1'b0);
          end else begin
            f0 = '{KIND_COUNT, don_q ? TAG_ON_COUNT : TAG_OFF_COUNT, cnt_d};
          end
        end
      end
      default: ;
    endcase

    // Carry out a completed command frame
    if (exec) begin
      case (p0_q)
        CMD_SET_SP: sp_d = 16'(p1_q) * 16'd100 + 16'(rx_byte_i);
        CMD_SP_UP:  sp_d = (sp_q > 16'd65435) ? 16'hFFFF : sp_q + 16'd100;
        CMD_SP_DOWN: sp_d = (sp_q >= 16'd100) ? sp_q - 16'd100 : 16'd0;
        CMD_CTL_TOGGLE: begin
          ctl_d = !ctl_q;
          nf = 2'd1;
          f0 = state_frame(ctl_d, doff_q, don_q);
          if (!ctl_d) drive_d = DRIVE_MID;
        end
        CMD_DELAY_ON, CMD_DELAY_OFF: begin
          on_kind = (p0_q == CMD_DELAY_ON);
          if (on_kind) drive_d = DRIVE_MID;
          don_d  = on_kind;
          doff_d = !on_kind;
          ctl_d  = !on_kind;
          cnt_d  = 16'(p1_q) * 16'd60 + 16'(rx_byte_i);
          nf = 2'd2;
          f0 = state_frame(ctl_d, doff_d, don_d);
          if (cnt_d == 16'd0) begin
            // zero count finishes at once
            ctl_d  = on_kind;
            don_d  = 1'b0;
            doff_d = 1'b0;
            if (!on_kind) drive_d = DRIVE_MID;
            f1 = state_frame(ctl_d, 1'b0, 1'b0);
          end else begin
            f1 = '{KIND_COUNT, on_kind ? TAG_ON_COUNT : TAG_OFF_COUNT, cnt_d};
          end
        end
        CMD_MANUAL: begin
          ctl_d = 1'b0;
          ml_d  = p1_q;
          man_d = !man_q;
        end
        CMD_TEMP_REPORT: begin
          rep_d = 1'b1;
          nf = 2'd1;
          f0 = '{KIND_TEMP, TAG_TEMP, {2'd0, temp_q}};
        end
        CMD_ON_COUNT, CMD_OFF_COUNT: begin
          nf = 2'd1;
          f0 = '{KIND_COUNT, p0_q, cnt_q};
        end
        CMD_STATE: begin
          nf = 2'd1;
          f0 = state_frame(ctl_q, doff_q, don_q);
        end
        default: ;
      endcase
    end

    job_o = '{nf, f0, f1, drive_d, ctl_d};
  end

  // Hold control state, advance on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      left_q  <= 2'd0;
      sp_q    <= 16'd0;
      temp_q  <= 14'd0;
      ctl_q   <= 1'b0;
      man_q   <= 1'b0;
      rep_q   <= 1'b0;
      don_q   <= 1'b0;
      doff_q  <= 1'b0;
      ml_q    <= 8'd0;
      cnt_q   <= 16'd0;
      drive_q <= DRIVE_MID;
    end else if (accept_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      sp_q    <= sp_d;
      temp_q  <= temp_d;
      ctl_q   <= ctl_d;
      man_q   <= man_d;
      rep_q   <= rep_d;
      don_q   <= don_d;
      doff_q  <= doff_d;
      ml_q    <= ml_d;
      cnt_q   <= cnt_d;
      drive_q <= drive_d;
    end
  end

  // Payload bytes
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
    end
  end

endmodule

// ===== hdl/sct_queue.sv =====
`timescale 1ns / 1ps
module sct_queue import sct_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  output logic pop_valid_o,
  input  logic pop_i,
  output job_t pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o      = (cnt_q == CW'(DEPTH));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      if (pop_i)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + CW'(1);
      else if (!push_i && pop_i) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule

// ===== hdl/sct_back.sv =====
`timescale 1ns / 1ps
module sct_back import sct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       job_pop_o,
  output back_stat_t stat_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic [7:0] dac_value_o,
  output logic       control_on_o,
  output logic       last_o
);

  job_t        jb_q;
  logic        busy_q;
  logic [3:0]  idx_q;
  logic        ov_q;

  logic [10:0] hi_q;
  logic [7:0]  lo_q;
  logic [15:0] dq_q;
  kind_e       kq_q;

  frame_t      cur;
  logic        second;
  logic [3:0]  pos, nbytes;
  logic        adv, last_byte;
  logic [7:0]  byte_v;
  logic [26:0] prod_t;
  logic [31:0] prod_c;
  logic [15:0] lo_full;

  assign second    = (idx_q >= 4'(FRAME_LEN));
  assign cur       = second ? jb_q.f1 : jb_q.f0;
  assign pos       = second ? idx_q - 4'(FRAME_LEN) : idx_q;
  assign nbytes    = (jb_q.nframes == 2'd0) ? 4'd1 : 4'(jb_q.nframes) * 4'(FRAME_LEN);
  assign last_byte = (idx_q == nbytes - 4'd1);
  assign adv       = busy_q && (!ov_q || out_ready_i);
  assign job_pop_o = !busy_q && job_valid_i;
  assign stat_o.busy = busy_q;

  // Divide the frame value into its two report bytes
  assign prod_t  = 27'(cur.data[13:0]) * 27'd5243;
  assign prod_c  = 32'(cur.data) * 32'd34953;
  assign lo_full = dq_q - 16'(hi_q) * ((kq_q == KIND_TEMP) ? 16'd100 : 16'd60)
                   - ((kq_q == KIND_COUNT) ? 16'd1 : 16'd0);

  always_ff @(posedge clk_i) begin
    hi_q <= (cur.kind == KIND_TEMP) ? 11'(prod_t[26:19]) : prod_c[31:21];
    dq_q <= cur.data;
    kq_q <= cur.kind;
    lo_q <= lo_full[7:0];
  end

  // Select the byte at the current position
  always_comb begin
    case (pos)
      4'd0:    byte_v = CH_C;
      4'd1:    byte_v = CH_O;
      4'd2:    byte_v = CH_M;
      4'd3:    byte_v = cur.tag;
      4'd4:    byte_v = (cur.kind == KIND_STATE) ? cur.data[7:0] : hi_q[7:0];
      default: byte_v = (cur.kind == KIND_STATE) ? STATE_PAD : lo_q;
    endcase
    if (jb_q.nframes == 2'd0) byte_v = 8'd0;
  end

  // Load jobs and step through their bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 4'd0;
    end else if (job_pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= 4'd0;
    end else if (adv) begin
      idx_q <= idx_q + 4'd1;
      if (last_byte) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) jb_q <= job_i;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tx_valid_o   <= (jb_q.nframes != 2'd0);
      tx_byte_o    <= byte_v;
      dac_value_o  <= jb_q.dac;
      control_on_o <= jb_q.ctl;
      last_o       <= last_byte;
    end
  end

  assign out_valid_o = ov_q;

endmodule

// ===== hdl/serial_command_thermostat.sv =====
`timescale 1ns / 1ps
// Serial-command thermostat. Takes received bytes, temperature samples and
// one-second ticks, one word per accepted item, and returns reply bytes one
// word per result, the final result of each item marked by last_o. The front
// accepts one item per cycle while its job queue (QUEUE_DEPTH jobs) has
// room; the back sends one result per cycle while out_ready_i does not hold
// it off, takes a new job only once the last is sent (1 to 12 results per
// item), and that byte sequencer sets the sustained rate.
module serial_command_thermostat import sct_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] adc_sample_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic [7:0] dac_value_o,
  output logic       control_on_o,
  output logic       last_o
);

  logic       accept, q_full, q_valid, q_pop;
  job_t       job_in, job_out;
  back_stat_t bstat;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  sct_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i     (accept),
    .command_i,
    .rx_byte_i,
    .adc_sample_i,
    .job_o        (job_in)
  );

  sct_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (accept),
    .push_data_i (job_in),
    .full_o      (q_full),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (job_out)
  );

  sct_back u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i (q_valid),
    .job_i       (job_out),
    .job_pop_o   (q_pop),
    .stat_o      (bstat),
    .out_valid_o,
    .out_ready_i,
    .tx_valid_o,
    .tx_byte_o,
    .dac_value_o,
    .control_on_o,
    .last_o
  );

`ifndef ASSERT_OFF
  // a full queue always has a job to give
  a_full_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> q_valid) else $error("queue full but empty");

  // a popped job keeps the back busy
  a_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> bstat.busy) else $error("back not busy after pop");

  // the back never pops while busy
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !bstat.busy) else $error("pop while busy");
`endif

endmodule
